// File: sv/fwsi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constant tables for the fuzzy wheel speed inference block.
// No dependencies; every other file imports this package.
package fwsi_pkg;

    // Trapezoid geometry in quarter millimetres, with span reciprocals floor(2^32/span)
    typedef struct packed {
        logic [14:0] l;
        logic [14:0] lm;
        logic [14:0] rm;
        logic [14:0] r;
        logic [10:0] ls;
        logic [10:0] rs;
        logic [30:0] lr;
        logic [30:0] rr;
    } trap_t;

    // Item tag that travels beside the data through every stage
    typedef struct packed {
        logic vld;
        logic mode;
        logic wheel;
        logic kill;
    } item_tag_t;

    typedef enum logic [1:0] {
        MU_ZERO,
        MU_FRAC,
        MU_FULL
    } mu_kind_t;

    localparam int NUM_SAMPLES = 10;

    localparam logic [30:0] RECIP_1305 = 31'd3291162;
    localparam logic [30:0] RECIP_1000 = 31'd4294967;
    localparam logic [30:0] RECIP_996  = 31'd4312216;
    localparam logic [30:0] RECIP_4    = 31'd1073741824;

    // Output set per rule, indexed [mode][wheel][rule]
    localparam logic [1:0] RULE_OUT [2][2][9] = '{
        '{ '{2'd1, 2'd0, 2'd0, 2'd2, 2'd1, 2'd1, 2'd2, 2'd1, 2'd2},
           '{2'd2, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1} },
        '{ '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1},
           '{2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1} }
    };

    // Sample positions; the tenth slot of the wide mode is unused
    localparam logic [9:0] SAMPLE_X [2][NUM_SAMPLES] = '{
        '{10'd100, 10'd200, 10'd300, 10'd400, 10'd500,
          10'd600, 10'd700, 10'd800, 10'd900, 10'd0},
        '{10'd10, 10'd20, 10'd30, 10'd40, 10'd50,
          10'd60, 10'd70, 10'd80, 10'd90, 10'd100}
    };

    // Q16 output set memberships at each sample after clamping, [mode][set][sample]
    localparam logic [16:0] OUT_MU [2][3][NUM_SAMPLES] = '{
        '{ '{17'd1310, 17'd1310, 17'd1310, 17'd1310, 17'd1310,
             17'd1310, 17'd1310, 17'd1310, 17'd1310, 17'd0},
           '{17'd65536, 17'd1310, 17'd1310, 17'd1310, 17'd1310,
             17'd1310, 17'd1310, 17'd1310, 17'd1310, 17'd0},
           '{17'd0, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
             17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd0} },
        '{ '{17'd65536, 17'd65536, 17'd52428, 17'd26214, 17'd2621,
             17'd2621, 17'd2621, 17'd2621, 17'd2621, 17'd2621},
           '{17'd0, 17'd0, 17'd13107, 17'd39321, 17'd65536,
             17'd40960, 17'd13653, 17'd2730, 17'd2730, 17'd2730},
           '{17'd0, 17'd0, 17'd0, 17'd0, 17'd0,
             17'd26214, 17'd52428, 17'd65536, 17'd65536, 17'd65536} }
    };

    function automatic trap_t fwsi_geo(input logic mode, input logic is_back,
                                       input logic [1:0] set_idx);
        trap_t g;
        begin
            g = '0;
            if (mode)
            begin
                case (set_idx)
                    2'd0: g = '{15'd0, 15'd4, 15'd3000, 15'd4000,
                                11'd4, 11'd1000, RECIP_4, RECIP_1000};
                    2'd1: g = '{15'd3000, 15'd4000, 15'd4004, 15'd5000,
                                11'd1000, 11'd996, RECIP_1000, RECIP_996};
                    2'd2: g = '{15'd4000, 15'd5000, 15'd5996, 15'd6000,
                                11'd1000, 11'd4, RECIP_1000, RECIP_4};
                    default: g = '0;
                endcase
            end
            else if (is_back)
            begin
                case (set_idx)
                    2'd0: g = '{15'd0, 15'd0, 15'd2000, 15'd3000,
                                11'd0, 11'd1000, 31'd0, RECIP_1000};
                    2'd1: g = '{15'd2000, 15'd3000, 15'd3000, 15'd4000,
                                11'd1000, 11'd1000, RECIP_1000, RECIP_1000};
                    2'd2: g = '{15'd3000, 15'd4000, 15'd5000, 15'd5000,
                                11'd1000, 11'd0, RECIP_1000, 31'd0};
                    default: g = '0;
                endcase
            end
            else
            begin
                case (set_idx)
                    2'd0: g = '{15'd0, 15'd0, 15'd2610, 15'd3915,
                                11'd0, 11'd1305, 31'd0, RECIP_1305};
                    2'd1: g = '{15'd2610, 15'd3915, 15'd3915, 15'd5220,
                                11'd1305, 11'd1305, RECIP_1305, RECIP_1305};
                    2'd2: g = '{15'd3915, 15'd5220, 15'd6525, 15'd6525,
                                11'd1305, 11'd0, RECIP_1305, 31'd0};
                    default: g = '0;
                endcase
            end
            return g;
        end
    endfunction

endpackage

// File: sv/fwsi_member.sv
`timescale 1ns / 1ps
// Three-stage trapezoid membership: clamp and region, reciprocal estimate, correction.
// Depends on fwsi_pkg.
module fwsi_member import fwsi_pkg::*;
(
    input  logic        clk,
    input  logic [14:0] x,
    input  trap_t       geo,
    output logic [16:0] mu
);

    mu_kind_t    kind_next, kind_reg, kind2_reg;
    logic [14:0] xc;
    logic [10:0] d_next, d_reg, d2_reg;
    logic [10:0] span_next, span_reg, span2_reg;
    logic [30:0] recip_next, recip_reg;
    logic [41:0] prod;
    logic [16:0] est_reg;
    logic [27:0] rem;
    logic [16:0] mu_next, mu_reg;

    // clamp into the set, then pick the edge
    always_comb
    begin
        xc = (x >= geo.r) ? geo.r - 15'd4 : x;
        if (xc == 15'd0)
        begin
            xc = 15'd4;
        end
        kind_next  = MU_ZERO;
        d_next     = '0;
        span_next  = '0;
        recip_next = '0;
        if (xc <= geo.l || xc >= geo.r)
        begin
            kind_next = MU_ZERO;
        end
        else if (xc < geo.lm)
        begin
            kind_next  = MU_FRAC;
            d_next     = 11'(xc - geo.l);
            span_next  = geo.ls;
            recip_next = geo.lr;
        end
        else if (xc > geo.rm)
        begin
            kind_next  = MU_FRAC;
            d_next     = 11'(geo.r - xc);
            span_next  = geo.rs;
            recip_next = geo.rr;
        end
        else
        begin
            kind_next = MU_FULL;
        end
    end

    assign prod = 42'(d_reg) * 42'(recip_reg);
    assign rem  = {1'b0, d2_reg, 16'd0} - 28'(est_reg) * 28'(span2_reg);

    // estimate is exact or one low: one compare fixes it
    always_comb
    begin
        case (kind2_reg)
            MU_FRAC: mu_next = (rem >= 28'(span2_reg)) ? est_reg + 17'd1 : est_reg;
            MU_FULL: mu_next = 17'd65536;
            default: mu_next = 17'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        d_reg     <= d_next;
        span_reg  <= span_next;
        recip_reg <= recip_next;
        kind2_reg <= kind_reg;
        d2_reg    <= d_reg;
        span2_reg <= span_reg;
        est_reg   <= prod[32:16];
        mu_reg    <= mu_next;
    end

    assign mu = mu_reg;

endmodule

// File: sv/fwsi_rules.sv
`timescale 1ns / 1ps
// Rule firing, max aggregation, clipping, sampling and centroid sums in six stages.
// Depends on fwsi_pkg.
module fwsi_rules import fwsi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  item_tag_t   tag_in,
    input  logic [16:0] muf [3],
    input  logic [16:0] mub [3],
    output item_tag_t   tag_out,
    output logic [29:0] num,
    output logic [19:0] den
);

    item_tag_t   tag_reg [6];
    logic [16:0] fs_next [9], fs_reg [9];
    logic [16:0] cut_next [3], cut_reg [3];
    logic [16:0] y_next [NUM_SAMPLES], y_reg [NUM_SAMPLES];
    logic [16:0] clip;
    logic [26:0] xy_reg [NUM_SAMPLES];
    logic [16:0] yd_reg [NUM_SAMPLES];
    logic [27:0] nump_reg [5];
    logic [17:0] denp_reg [5];
    logic [29:0] num_next, num_reg;
    logic [19:0] den_next, den_reg;
    logic [33:0] fprod [9];

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            fprod[i]   = 34'(muf[i / 3]) * 34'(mub[i % 3]);
            fs_next[i] = fprod[i][32:16];
        end
    end

    // strongest rule per output set
    always_comb
    begin
        for (int s = 0; s < 3; s++)
        begin
            cut_next[s] = '0;
        end
        for (int i = 0; i < 9; i++)
        begin
            for (int s = 0; s < 3; s++)
            begin
                if (RULE_OUT[tag_reg[0].mode][tag_reg[0].wheel][i] == 2'(s)
                    && fs_reg[i] > cut_next[s])
                begin
                    cut_next[s] = fs_reg[i];
                end
            end
        end
    end

    // clip each set at its strength, take the max at each sample
    always_comb
    begin
        clip = '0;
        for (int k = 0; k < NUM_SAMPLES; k++)
        begin
            y_next[k] = '0;
            for (int s = 0; s < 3; s++)
            begin
                clip = (OUT_MU[tag_reg[1].mode][s][k] < cut_reg[s])
                     ? OUT_MU[tag_reg[1].mode][s][k] : cut_reg[s];
                if (clip > y_next[k])
                begin
                    y_next[k] = clip;
                end
            end
        end
    end

    always_comb
    begin
        num_next = '0;
        den_next = '0;
        for (int p = 0; p < 5; p++)
        begin
            num_next = num_next + 30'(nump_reg[p]);
            den_next = den_next + 20'(denp_reg[p]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < 6; t++)
            begin
                tag_reg[t] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= tag_in;
            for (int t = 1; t < 6; t++)
            begin
                tag_reg[t] <= tag_reg[t - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fs_reg  <= fs_next;
        cut_reg <= cut_next;
        y_reg   <= y_next;
        for (int k = 0; k < NUM_SAMPLES; k++)
        begin
            xy_reg[k] <= 27'(SAMPLE_X[tag_reg[2].mode][k]) * 27'(y_reg[k]);
            yd_reg[k] <= y_reg[k];
        end
        for (int p = 0; p < 5; p++)
        begin
            nump_reg[p] <= 28'(xy_reg[2 * p]) + 28'(xy_reg[2 * p + 1]);
            denp_reg[p] <= 18'(yd_reg[2 * p]) + 18'(yd_reg[2 * p + 1]);
        end
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign tag_out = tag_reg[5];
    assign num     = num_reg;
    assign den     = den_reg;

endmodule

// File: sv/fwsi_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, plus the result register.
// Depends on fwsi_pkg.
module fwsi_div import fwsi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  item_tag_t   tag_in,
    input  logic [29:0] num,
    input  logic [19:0] den,
    output logic        done,
    output logic [15:0] wheel_speed,
    output logic        no_rule_fired
);

    localparam int NSTG = 16;

    item_tag_t   tag_reg [NSTG + 1];
    logic [19:0] rem_reg [NSTG + 1], rem_next [NSTG + 1];
    logic [15:0] low_reg [NSTG + 1], low_next [NSTG + 1];
    logic [15:0] q_reg [NSTG + 1], q_next [NSTG + 1];
    logic [19:0] den_reg [NSTG + 1], den_next [NSTG + 1];
    logic [20:0] trial;
    logic        done_reg, nrf_reg;
    logic [15:0] speed_reg;

    // dividend is num*64; its top 20 bits already sit below den
    always_comb
    begin
        trial       = '0;
        rem_next[0] = num[29:10];
        low_next[0] = {num[9:0], 6'd0};
        q_next[0]   = '0;
        den_next[0] = den;
        for (int k = 1; k <= NSTG; k++)
        begin
            trial       = {rem_reg[k - 1], low_reg[k - 1][15]};
            low_next[k] = {low_reg[k - 1][14:0], 1'b0};
            den_next[k] = den_reg[k - 1];
            if (trial >= 21'(den_reg[k - 1]))
            begin
                rem_next[k] = 20'(trial - 21'(den_reg[k - 1]));
                q_next[k]   = {q_reg[k - 1][14:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[19:0];
                q_next[k]   = {q_reg[k - 1][14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NSTG; k++)
            begin
                tag_reg[k] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            tag_reg[0] <= tag_in;
            for (int k = 1; k <= NSTG; k++)
            begin
                tag_reg[k] <= tag_reg[k - 1];
            end
            done_reg <= tag_reg[NSTG].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        if (tag_reg[NSTG].kill || den_reg[NSTG] == 20'd0)
        begin
            speed_reg <= '0;
        end
        else
        begin
            speed_reg <= q_reg[NSTG];
        end
        nrf_reg <= !tag_reg[NSTG].kill && den_reg[NSTG] == 20'd0;
    end

    assign done          = done_reg;
    assign wheel_speed   = speed_reg;
    assign no_rule_fired = nrf_reg;

endmodule

// File: sv/fuzzy_wheel_speed_inference.sv
`timescale 1ns / 1ps
// Top level of the fuzzy wheel speed inference pipeline.
// Depends on fwsi_pkg, fwsi_member, fwsi_rules and fwsi_div.

// Fully pipelined fuzzy speed controller: one word (front range, back range,
// wheel select) may be started on every clock and busy never rises. Each word
// passes 27 register stages and produces exactly one result, shown for a
// single cycle with done high; the receiver cannot stall, so capture it then.
// The stages are the 3-stage membership divide, 6 rule/centroid stages, the
// divider input register, the 16-stage quotient pipeline and one result
// register. table_select may be written only while no word is in flight; each
// word carries the mode it was started with.
module fuzzy_wheel_speed_inference import fwsi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [12:0] front_range,
    input  logic [12:0] back_range,
    input  logic [1:0]  func,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    output logic        done,
    output logic [15:0] wheel_speed,
    output logic        no_rule_fired
);

    logic        table_select_reg;
    item_tag_t   tag_next;
    item_tag_t   tag_reg [3];
    logic [14:0] front_q, back_q;
    logic [16:0] muf [3];
    logic [16:0] mub [3];
    item_tag_t   rules_tag;
    logic [29:0] num;
    logic [19:0] den;

    // never blocks: a new word enters every cycle
    assign busy = 1'b0;

    // ranges move to quarter millimetres to match the breakpoint tables
    assign front_q = {front_range, 2'b00};
    assign back_q  = {back_range, 2'b00};

    always_comb
    begin
        tag_next.vld   = start;
        tag_next.mode  = table_select_reg;
        tag_next.wheel = func[0];
        tag_next.kill  = func[1];
    end

    // hold the mode register; write it only when idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_select_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            table_select_reg <= cfg_wr_data;
        end
    end

    // advance the tag alongside the three membership stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < 3; t++)
            begin
                tag_reg[t] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= tag_next;
            tag_reg[1] <= tag_reg[0];
            tag_reg[2] <= tag_reg[1];
        end
    end

    // six trapezoid memberships, one per input set, in parallel
    for (genvar g = 0; g < 3; g++)
    begin : g_mu
        fwsi_member u_front
        (
            .clk (clk),
            .x   (front_q),
            .geo (fwsi_geo(table_select_reg, 1'b0, 2'(g))),
            .mu  (muf[g])
        );
        fwsi_member u_back
        (
            .clk (clk),
            .x   (back_q),
            .geo (fwsi_geo(table_select_reg, 1'b1, 2'(g))),
            .mu  (mub[g])
        );
    end

    // rule firing through centroid sums
    fwsi_rules u_rules
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag_reg[2]),
        .muf     (muf),
        .mub     (mub),
        .tag_out (rules_tag),
        .num     (num),
        .den     (den)
    );

    // centroid divide; the weighted mean never exceeds 900, so 16 bits always hold it
    fwsi_div u_div
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .tag_in        (rules_tag),
        .num           (num),
        .den           (den),
        .done          (done),
        .wheel_speed   (wheel_speed),
        .no_rule_fired (no_rule_fired)
    );

endmodule
